FILE: hdl/hnem_pkg.sv
// Shared types and constants for the hybrid NoC hop and energy monitor.
`default_nettype none
package hnem_pkg;

    // Field widths
    localparam int ADDR_W    = 48;
    localparam int LEN_W     = 32;
    localparam int NODE_W    = 6;
    localparam int HOP_W     = 4;
    localparam int RATE_W    = 12;
    localparam int CNT_W     = 32;
    localparam int HSUM_W    = 40;
    localparam int ESUM_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // Energy per reference is (wired rate * hops + wireless rate) * 512 bits, done as a shift
    localparam int XFER_SHIFT = 9;
    localparam int EHOP_W     = 26;

    // Input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_REF  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIRED_EXACT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIRED_APPROX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIRELESS_EXACT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIRELESS_APPROX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_MAX        = 3'd4;

    // Configuration reset values
    localparam logic [RATE_W-1:0] RST_WIRED_EXACT     = 12'd527;
    localparam logic [RATE_W-1:0] RST_WIRED_APPROX    = 12'd152;
    localparam logic [RATE_W-1:0] RST_WIRELESS_EXACT  = 12'd1470;
    localparam logic [RATE_W-1:0] RST_WIRELESS_APPROX = 12'd998;
    localparam logic [HOP_W-1:0]  RST_DIST_MAX        = 4'd5;

    // Corner wireless hubs
    localparam logic [NODE_W-1:0] HUB_LL = 6'd0;
    localparam logic [NODE_W-1:0] HUB_LR = 6'd7;
    localparam logic [NODE_W-1:0] HUB_UL = 6'd56;
    localparam logic [NODE_W-1:0] HUB_UR = 6'd63;

    typedef struct packed {
        logic [RATE_W-1:0] wired_exact;
        logic [RATE_W-1:0] wired_approx;
        logic [RATE_W-1:0] wireless_exact;
        logic [RATE_W-1:0] wireless_approx;
        logic [HOP_W-1:0]  dist_max;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic              scan;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } scan_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } scan_sts_t;

    typedef struct packed {
        logic              wireless;
        logic [HOP_W-1:0]  wired_hops;
        logic [HOP_W-1:0]  mesh_hops;
        logic [EHOP_W-1:0] e_exact;
        logic [EHOP_W-1:0] e_approx;
    } route_t;

endpackage
`default_nettype wire

FILE: hdl/hybrid_noc_hop_energy_monitor_top.sv
// Top level of the hybrid NoC hop and energy monitor: sequencer, config and totals.
`default_nettype none
// Tracks hops and transfer energy on a hybrid wired/wireless 8x8 mesh. Opcode 0
// words append an approximate memory region to a table of REGION_DEPTH entries
// (a load into a full table is dropped and reported by table_full); opcode 1 words
// are memory references that are checked against every loaded region, routed
// wired or through the corner wireless hub of the source quadrant, and added to
// saturating running totals, which come back with each result word. The block
// takes one word at a time. A reference takes longer the more regions are loaded,
// because the table is scanned one entry per cycle through a single memory read
// port feeding one overlap comparator. The table needs no clearing after reset;
// only loaded entries are read. A finished result sits in the output register
// while the next word is accepted.
module hybrid_noc_hop_energy_monitor_top #(
    parameter int REGION_DEPTH = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [hnem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hnem_pkg::CFG_DAT_W-1:0]  cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            opcode,
    input  wire logic [hnem_pkg::ADDR_W-1:0]     address,
    input  wire logic [hnem_pkg::LEN_W-1:0]      length,
    input  wire logic [hnem_pkg::NODE_W-1:0]     src_node,
    input  wire logic [hnem_pkg::NODE_W-1:0]     dst_node,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 table_full,
    output logic                                 approx_hit,
    output logic                                 went_wireless,
    output logic [hnem_pkg::HOP_W-1:0]           wired_hops,
    output logic [hnem_pkg::HOP_W-1:0]           mesh_hops,
    output logic [hnem_pkg::CNT_W-1:0]           wired_count,
    output logic [hnem_pkg::CNT_W-1:0]           wireless_count,
    output logic [hnem_pkg::HSUM_W-1:0]          wired_hops_total,
    output logic [hnem_pkg::HSUM_W-1:0]          mesh_hops_total,
    output logic [hnem_pkg::ESUM_W-1:0]          energy_exact_total,
    output logic [hnem_pkg::ESUM_W-1:0]          energy_approx_total
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMD  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_ACC  = 2'd3;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    hnem_pkg::cfg_t                 cfg_reg;

    logic                           op_reg;
    logic [hnem_pkg::ADDR_W-1:0]    addr_reg;
    logic [hnem_pkg::LEN_W-1:0]     len_reg;
    logic [hnem_pkg::NODE_W-1:0]    src_reg;
    logic [hnem_pkg::NODE_W-1:0]    dst_reg;

    hnem_pkg::scan_cmd_t            scan_cmd;
    hnem_pkg::scan_sts_t            scan_sts;
    hnem_pkg::route_t               route;
    logic                           hit_reg;
    logic                           full_reg;

    logic                           out_valid_reg;
    logic                           full_out_reg;
    logic                           hit_out_reg;
    logic                           wl_out_reg;
    logic [hnem_pkg::HOP_W-1:0]     wired_out_reg;
    logic [hnem_pkg::HOP_W-1:0]     mesh_out_reg;
    logic [hnem_pkg::CNT_W-1:0]     wired_cnt_reg;
    logic [hnem_pkg::CNT_W-1:0]     wireless_cnt_reg;
    logic [hnem_pkg::HSUM_W-1:0]    wired_sum_reg;
    logic [hnem_pkg::HSUM_W-1:0]    mesh_sum_reg;
    logic [hnem_pkg::ESUM_W-1:0]    ex_sum_reg;
    logic [hnem_pkg::ESUM_W-1:0]    ap_sum_reg;

    logic                           in_acc;
    logic                           commit;
    logic [hnem_pkg::CNT_W:0]       wired_cnt_add;
    logic [hnem_pkg::CNT_W:0]       wireless_cnt_add;
    logic [hnem_pkg::HSUM_W:0]      wired_sum_add;
    logic [hnem_pkg::HSUM_W:0]      mesh_sum_add;
    logic [hnem_pkg::ESUM_W:0]      ex_sum_add;
    logic [hnem_pkg::ESUM_W:0]      ap_sum_add;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign commit   = (state_reg == S_ACC) && (!out_valid_reg || out_ready);

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wired_exact     <= hnem_pkg::RST_WIRED_EXACT;
            cfg_reg.wired_approx    <= hnem_pkg::RST_WIRED_APPROX;
            cfg_reg.wireless_exact  <= hnem_pkg::RST_WIRELESS_EXACT;
            cfg_reg.wireless_approx <= hnem_pkg::RST_WIRELESS_APPROX;
            cfg_reg.dist_max        <= hnem_pkg::RST_DIST_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hnem_pkg::REG_WIRED_EXACT:     cfg_reg.wired_exact     <= cfg_data;
                hnem_pkg::REG_WIRED_APPROX:    cfg_reg.wired_approx    <= cfg_data;
                hnem_pkg::REG_WIRELESS_EXACT:  cfg_reg.wireless_exact  <= cfg_data;
                hnem_pkg::REG_WIRELESS_APPROX: cfg_reg.wireless_approx <= cfg_data;
                hnem_pkg::REG_DIST_MAX:
                    cfg_reg.dist_max <= cfg_data[hnem_pkg::HOP_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
            len_reg  <= length;
            src_reg  <= src_node;
            dst_reg  <= dst_node;
        end
        if (scan_sts.done)
        begin
            hit_reg  <= scan_sts.hit;
            full_reg <= scan_sts.full;
        end
    end

    // Issue the table command from S_CMD, in the cycle after accept
    always_comb
    begin
        scan_cmd.load = (state_reg == S_CMD) && (op_reg == hnem_pkg::OP_LOAD);
        scan_cmd.scan = (state_reg == S_CMD) && (op_reg == hnem_pkg::OP_REF);
        scan_cmd.addr = addr_reg;
        scan_cmd.len  = len_reg;
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc) state_next = S_CMD;
            S_CMD:  state_next = S_WAIT;
            S_WAIT: if (scan_sts.done) state_next = S_ACC;
            S_ACC:  if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    hnem_region_scan #(
        .REGION_DEPTH(REGION_DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scan_cmd),
        .sts   (scan_sts)
    );

    hnem_route_calc u_route (
        .clk   (clk),
        .calc  (scan_sts.done),
        .src   (src_reg),
        .dst   (dst_reg),
        .hit   (scan_sts.hit),
        .cfg   (cfg_reg),
        .route (route)
    );

    // Saturating sums: a carry out pins the total at its maximum
    always_comb
    begin
        wired_cnt_add    = {1'b0, wired_cnt_reg} + (hnem_pkg::CNT_W + 1)'(!route.wireless);
        wireless_cnt_add = {1'b0, wireless_cnt_reg} + (hnem_pkg::CNT_W + 1)'(route.wireless);
        wired_sum_add    = {1'b0, wired_sum_reg} + (hnem_pkg::HSUM_W + 1)'(route.wired_hops);
        mesh_sum_add     = {1'b0, mesh_sum_reg} + (hnem_pkg::HSUM_W + 1)'(route.mesh_hops);
        ex_sum_add       = {1'b0, ex_sum_reg} + (hnem_pkg::ESUM_W + 1)'(route.e_exact);
        ap_sum_add       = {1'b0, ap_sum_reg} + (hnem_pkg::ESUM_W + 1)'(route.e_approx);
    end

    // Update the totals and load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            wired_cnt_reg    <= '0;
            wireless_cnt_reg <= '0;
            wired_sum_reg    <= '0;
            mesh_sum_reg     <= '0;
            ex_sum_reg       <= '0;
            ap_sum_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == hnem_pkg::OP_REF)
                begin
                    wired_cnt_reg <= wired_cnt_add[hnem_pkg::CNT_W] ? '1
                                   : wired_cnt_add[hnem_pkg::CNT_W-1:0];
                    wireless_cnt_reg <= wireless_cnt_add[hnem_pkg::CNT_W] ? '1
                                      : wireless_cnt_add[hnem_pkg::CNT_W-1:0];
                    wired_sum_reg <= wired_sum_add[hnem_pkg::HSUM_W] ? '1
                                   : wired_sum_add[hnem_pkg::HSUM_W-1:0];
                    mesh_sum_reg <= mesh_sum_add[hnem_pkg::HSUM_W] ? '1
                                  : mesh_sum_add[hnem_pkg::HSUM_W-1:0];
                    ex_sum_reg <= ex_sum_add[hnem_pkg::ESUM_W] ? '1
                                : ex_sum_add[hnem_pkg::ESUM_W-1:0];
                    ap_sum_reg <= ap_sum_add[hnem_pkg::ESUM_W] ? '1
                                : ap_sum_add[hnem_pkg::ESUM_W-1:0];
                end
            end
        end
    end

    // Per-word result fields; a region load sets only table_full, the others are zero
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            if (op_reg == hnem_pkg::OP_REF)
            begin
                full_out_reg  <= 1'b0;
                hit_out_reg   <= hit_reg;
                wl_out_reg    <= route.wireless;
                wired_out_reg <= route.wired_hops;
                mesh_out_reg  <= route.mesh_hops;
            end
            else
            begin
                full_out_reg  <= full_reg;
                hit_out_reg   <= 1'b0;
                wl_out_reg    <= 1'b0;
                wired_out_reg <= '0;
                mesh_out_reg  <= '0;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign table_full          = full_out_reg;
    assign approx_hit          = hit_out_reg;
    assign went_wireless       = wl_out_reg;
    assign wired_hops          = wired_out_reg;
    assign mesh_hops           = mesh_out_reg;
    assign wired_count         = wired_cnt_reg;
    assign wireless_count      = wireless_cnt_reg;
    assign wired_hops_total    = wired_sum_reg;
    assign mesh_hops_total     = mesh_sum_reg;
    assign energy_exact_total  = ex_sum_reg;
    assign energy_approx_total = ap_sum_reg;

    // One word at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // The table only reports done while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        scan_sts.done |-> (state_reg == S_WAIT))
        else $error("table done outside the wait state");

    // A wireless route never needs more than six wired hops to its hub
    a_hub_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && wl_out_reg) |-> (wired_out_reg <= 4'd6))
        else $error("wired leg to hub too long");

    // The exact energy and mesh hop totals never move backwards
    a_totals_grow: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (ex_sum_reg >= $past(ex_sum_reg)) && (mesh_sum_reg >= $past(mesh_sum_reg)))
        else $error("running total decreased");

endmodule
`default_nettype wire

FILE: hdl/hnem_region_scan.sv
// Region table memory with its load path and one-entry-per-cycle overlap scan.
`default_nettype none
module hnem_region_scan #(
    parameter int REGION_DEPTH = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hnem_pkg::scan_cmd_t  cmd,
    output hnem_pkg::scan_sts_t       sts
);
    localparam int CW = $clog2(REGION_DEPTH + 1);
    localparam int IW = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;

    logic [hnem_pkg::ADDR_W-1:0] base_mem [REGION_DEPTH];
    logic [hnem_pkg::LEN_W-1:0]  size_mem [REGION_DEPTH];

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 idx_reg;
    logic                          busy_reg;
    logic                          rd_vld_reg;
    logic                          hit_reg;
    logic                          full_reg;
    logic                          done_reg;
    logic [hnem_pkg::ADDR_W-1:0]   addr_reg;
    logic [hnem_pkg::ADDR_W:0]     end_reg;
    logic [hnem_pkg::ADDR_W-1:0]   rd_base_reg;
    logic [hnem_pkg::LEN_W-1:0]    rd_size_reg;

    logic                          wr_en;
    logic                          rd_en;
    logic                          cmp_hit;
    logic [hnem_pkg::ADDR_W:0]     region_lim;

    assign wr_en = cmd.load && (count_reg != CW'(REGION_DEPTH));
    assign rd_en = busy_reg && (idx_reg < count_reg);

    // Overlap: addr < base + size and addr + len >= base
    assign region_lim = {1'b0, rd_base_reg} + {{(hnem_pkg::ADDR_W + 1 - hnem_pkg::LEN_W){1'b0}},
                                               rd_size_reg};
    assign cmp_hit = ({1'b0, addr_reg} < region_lim) && (end_reg >= {1'b0, rd_base_reg});

    // Write a loaded region, read one entry per scan cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_mem[count_reg[IW-1:0]] <= cmd.addr;
            size_mem[count_reg[IW-1:0]] <= cmd.len;
        end
        if (rd_en)
        begin
            rd_base_reg <= base_mem[idx_reg[IW-1:0]];
            rd_size_reg <= size_mem[idx_reg[IW-1:0]];
        end
    end

    // Reference window, held for the whole scan
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            addr_reg <= cmd.addr;
            end_reg  <= {1'b0, cmd.addr} + {{(hnem_pkg::ADDR_W + 1 - hnem_pkg::LEN_W){1'b0}},
                                            cmd.len};
        end
    end

    // Sequence the load and the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            busy_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
            full_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.load)
            begin
                hit_reg  <= 1'b0;
                full_reg <= !wr_en;
                done_reg <= 1'b1;
                if (wr_en)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            else if (cmd.scan)
            begin
                busy_reg   <= 1'b1;
                idx_reg    <= '0;
                rd_vld_reg <= 1'b0;
                hit_reg    <= 1'b0;
                full_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                rd_vld_reg <= rd_en;
                if (rd_en)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (rd_vld_reg && cmp_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (!rd_en && !rd_vld_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.hit  = hit_reg;
    assign sts.full = full_reg;

endmodule
`default_nettype wire

FILE: hdl/hnem_route_calc.sv
// Mesh distance, hub choice, hop counts and per-reference energy, registered.
`default_nettype none
module hnem_route_calc (
    input  wire logic                          clk,
    input  wire logic                          calc,
    input  wire logic [hnem_pkg::NODE_W-1:0]   src,
    input  wire logic [hnem_pkg::NODE_W-1:0]   dst,
    input  wire logic                          hit,
    input  wire hnem_pkg::cfg_t                cfg,
    output hnem_pkg::route_t                   route
);
    // Manhattan distance on the 8x8 mesh
    function automatic logic [hnem_pkg::HOP_W-1:0] mesh_dist(
        input logic [hnem_pkg::NODE_W-1:0] a,
        input logic [hnem_pkg::NODE_W-1:0] b
    );
        logic [2:0] dx;
        logic [2:0] dy;
        dx = (a[2:0] > b[2:0]) ? (a[2:0] - b[2:0]) : (b[2:0] - a[2:0]);
        dy = (a[5:3] > b[5:3]) ? (a[5:3] - b[5:3]) : (b[5:3] - a[5:3]);
        return {1'b0, dx} + {1'b0, dy};
    endfunction

    logic [hnem_pkg::HOP_W-1:0]   mesh;
    logic [hnem_pkg::HOP_W-1:0]   wired;
    logic                         wl;
    logic [hnem_pkg::NODE_W-1:0]  hub;
    logic [hnem_pkg::RATE_W-1:0]  wr_rate;
    logic [hnem_pkg::RATE_W-1:0]  wl_rate;
    logic [16:0]                  ex_sum;
    logic [16:0]                  ap_sum;
    hnem_pkg::route_t             route_reg;

    // Pick the corner hub of the source's quadrant
    always_comb
    begin
        mesh = mesh_dist(src, dst);
        wl   = mesh > cfg.dist_max;
        if (src[2])
        begin
            hub = src[5] ? hnem_pkg::HUB_UR : hnem_pkg::HUB_LR;
        end
        else
        begin
            hub = src[5] ? hnem_pkg::HUB_UL : hnem_pkg::HUB_LL;
        end
        wired = wl ? mesh_dist(src, hub) : mesh;
    end

    // Energy per bit for this reference, exact and approximate rates
    always_comb
    begin
        wr_rate = hit ? cfg.wired_approx : cfg.wired_exact;
        wl_rate = hit ? cfg.wireless_approx : cfg.wireless_exact;
        ex_sum  = 17'(wired * cfg.wired_exact)
                + (wl ? 17'(cfg.wireless_exact) : 17'd0);
        ap_sum  = 17'(wired * wr_rate) + (wl ? 17'(wl_rate) : 17'd0);
    end

    // Hold the result for the accumulate step
    always_ff @(posedge clk)
    begin
        if (calc)
        begin
            route_reg.wireless   <= wl;
            route_reg.wired_hops <= wired;
            route_reg.mesh_hops  <= mesh;
            route_reg.e_exact    <= {ex_sum, {hnem_pkg::XFER_SHIFT{1'b0}}};
            route_reg.e_approx   <= {ap_sum, {hnem_pkg::XFER_SHIFT{1'b0}}};
        end
    end

    assign route = route_reg;

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the hybrid NoC hop and energy monitor top level.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hnem_pkg::*;

    localparam int          DEPTH         = 256;
    localparam int          HALF_PERIOD   = 5;
    localparam int          RESET_CYCLES  = 6;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          TAIL_CYCLES   = 300;
    localparam int          IDLE_PAUSE    = 4;
    localparam int          LONG_HOLD     = 400;
    localparam int          MAX_REPORTS   = 10;
    localparam int          WINDOW        = 65536;
    localparam logic [63:0] BITS_PER_WORD = 64'd512;
    localparam logic [63:0] CNT_MAX       = 64'hFFFF_FFFF;
    localparam logic [63:0] HSUM_MAX      = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] ESUM_MAX      = '1;
    localparam logic [ADDR_W-1:0]    ADDR_MAX   = '1;
    localparam logic [LEN_W-1:0]     LEN_MAX    = '1;
    localparam logic [RATE_W-1:0]    RATE_MAX   = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic              table_full;
        logic              approx_hit;
        logic              went_wireless;
        logic [HOP_W-1:0]  wired_hops;
        logic [HOP_W-1:0]  mesh_hops;
        logic [CNT_W-1:0]  wired_count;
        logic [CNT_W-1:0]  wireless_count;
        logic [HSUM_W-1:0] wired_hops_total;
        logic [HSUM_W-1:0] mesh_hops_total;
        logic [ESUM_W-1:0] energy_exact_total;
        logic [ESUM_W-1:0] energy_approx_total;
    } monitor_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 opcode;
    logic [ADDR_W-1:0]    address;
    logic [LEN_W-1:0]     length;
    logic [NODE_W-1:0]    src_node;
    logic [NODE_W-1:0]    dst_node;
    logic                 out_valid;
    logic                 out_ready;
    logic                 table_full;
    logic                 approx_hit;
    logic                 went_wireless;
    logic [HOP_W-1:0]     wired_hops;
    logic [HOP_W-1:0]     mesh_hops;
    logic [CNT_W-1:0]     wired_count;
    logic [CNT_W-1:0]     wireless_count;
    logic [HSUM_W-1:0]    wired_hops_total;
    logic [HSUM_W-1:0]    mesh_hops_total;
    logic [ESUM_W-1:0]    energy_exact_total;
    logic [ESUM_W-1:0]    energy_approx_total;

    // Shadow of the block: configuration, region table and running totals
    cfg_t              shadow_cfg;
    logic [ADDR_W-1:0] region_base_q [DEPTH];
    logic [LEN_W-1:0]  region_len_q  [DEPTH];
    int unsigned       region_fill;
    logic [63:0]       wired_tally;
    logic [63:0]       wireless_tally;
    logic [63:0]       wired_hop_acc;
    logic [63:0]       mesh_hop_acc;
    logic [63:0]       exact_energy_acc;
    logic [63:0]       approx_energy_acc;

    monitor_result_t   results_due [$];

    // Shared run controls and statistics
    bit                no_idle;
    int                hold_cycles;
    int                failures;
    int                words_sent;
    int                loads_sent;
    int                loads_dropped;
    int                results_checked;
    int                hits_seen;
    int                wireless_seen;
    int                configs_applied;

    hybrid_noc_hop_energy_monitor_top #(
        .REGION_DEPTH (DEPTH)
    ) u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (opcode),
        .address             (address),
        .length              (length),
        .src_node            (src_node),
        .dst_node            (dst_node),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .table_full          (table_full),
        .approx_hit          (approx_hit),
        .went_wireless       (went_wireless),
        .wired_hops          (wired_hops),
        .mesh_hops           (mesh_hops),
        .wired_count         (wired_count),
        .wireless_count      (wireless_count),
        .wired_hops_total    (wired_hops_total),
        .mesh_hops_total     (mesh_hops_total),
        .energy_exact_total  (energy_exact_total),
        .energy_approx_total (energy_approx_total)
    );

    // Free-running clock
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Add and stick at the limit
    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
        if (a >= lim || b > lim - a)
            return lim;
        return a + b;
    endfunction

    // Manhattan distance on the 8x8 mesh
    function automatic logic [HOP_W-1:0] mesh_distance(logic [NODE_W-1:0] a,
                                                       logic [NODE_W-1:0] b);
        logic [2:0] dx;
        logic [2:0] dy;
        dx = (a[2:0] > b[2:0]) ? a[2:0] - b[2:0] : b[2:0] - a[2:0];
        dy = (a[5:3] > b[5:3]) ? a[5:3] - b[5:3] : b[5:3] - a[5:3];
        return {1'b0, dx} + {1'b0, dy};
    endfunction

    // Advance the shadow by one accepted word and return the result it must produce
    function automatic monitor_result_t step_monitor(logic op, logic [ADDR_W-1:0] a,
                                                     logic [LEN_W-1:0] l,
                                                     logic [NODE_W-1:0] s,
                                                     logic [NODE_W-1:0] d);
        monitor_result_t  r;
        longint           ref_lo;
        longint           ref_hi;
        longint           reg_lo;
        longint           reg_hi;
        logic [NODE_W-1:0] hub;
        logic [RATE_W-1:0] wr_rate;
        logic [RATE_W-1:0] wl_rate;
        logic [63:0]      wl_exact;
        logic [63:0]      wl_approx;
        logic [63:0]      e_exact;
        logic [63:0]      e_approx;
        r = '0;
        if (op == OP_LOAD)
        begin
            if (region_fill >= DEPTH)
                r.table_full = 1'b1;
            else
            begin
                region_base_q[region_fill] = a;
                region_len_q[region_fill]  = l;
                region_fill++;
            end
        end
        else
        begin
            // Reference covers its end byte; a region ends one byte before base+size
            ref_lo = $signed({16'b0, a});
            ref_hi = ref_lo + $signed({32'b0, l});
            for (int i = 0; i < region_fill; i++)
            begin
                reg_lo = $signed({16'b0, region_base_q[i]});
                reg_hi = reg_lo + $signed({32'b0, region_len_q[i]}) - 64'sd1;
                if (ref_lo <= reg_hi && ref_hi >= reg_lo)
                    r.approx_hit = 1'b1;
            end

            // Route: wired to the destination, or wired to the quadrant hub then wireless
            r.mesh_hops = mesh_distance(s, d);
            hub = d;
            if (r.mesh_hops > shadow_cfg.dist_max)
            begin
                if (s[2:0] > 3'd3)
                    hub = (s[5:3] > 3'd3) ? HUB_UR : HUB_LR;
                else
                    hub = (s[5:3] > 3'd3) ? HUB_UL : HUB_LL;
                r.went_wireless = 1'b1;
                wireless_tally = sat_add(wireless_tally, 64'd1, CNT_MAX);
            end
            else
                wired_tally = sat_add(wired_tally, 64'd1, CNT_MAX);
            r.wired_hops = mesh_distance(s, hub);
            wired_hop_acc = sat_add(wired_hop_acc, 64'(r.wired_hops), HSUM_MAX);
            mesh_hop_acc  = sat_add(mesh_hop_acc, 64'(r.mesh_hops), HSUM_MAX);

            // Energy for one 512-bit transfer at exact and at approximate rates
            wr_rate   = r.approx_hit ? shadow_cfg.wired_approx : shadow_cfg.wired_exact;
            wl_rate   = r.approx_hit ? shadow_cfg.wireless_approx : shadow_cfg.wireless_exact;
            wl_exact  = r.went_wireless ? 64'(shadow_cfg.wireless_exact) : 64'd0;
            wl_approx = r.went_wireless ? 64'(wl_rate) : 64'd0;
            e_exact   = (64'(r.wired_hops) * 64'(shadow_cfg.wired_exact) + wl_exact)
                        * BITS_PER_WORD;
            e_approx  = (64'(r.wired_hops) * 64'(wr_rate) + wl_approx) * BITS_PER_WORD;
            exact_energy_acc  = sat_add(exact_energy_acc, e_exact, ESUM_MAX);
            approx_energy_acc = sat_add(approx_energy_acc, e_approx, ESUM_MAX);
        end
        r.wired_count         = wired_tally[CNT_W-1:0];
        r.wireless_count      = wireless_tally[CNT_W-1:0];
        r.wired_hops_total    = wired_hop_acc[HSUM_W-1:0];
        r.mesh_hops_total     = mesh_hop_acc[HSUM_W-1:0];
        r.energy_exact_total  = exact_energy_acc;
        r.energy_approx_total = approx_energy_acc;
        return r;
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(logic op, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l,
                             logic [NODE_W-1:0] s, logic [NODE_W-1:0] d);
        int gap;
        monitor_result_t r;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        address  <= a;
        length   <= l;
        src_node <= s;
        dst_node <= d;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        r = step_monitor(op, a, l, s, d);
        results_due.push_back(r);
        words_sent++;
        if (op == OP_LOAD)
            loads_sent++;
        if (r.table_full)
            loads_dropped++;
        if (r.approx_hit)
            hits_seen++;
        if (r.went_wireless)
            wireless_seen++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    // Drive one register write for a cycle; the caller lowers the enable
    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_WIRED_EXACT:     shadow_cfg.wired_exact     = data[RATE_W-1:0];
            REG_WIRED_APPROX:    shadow_cfg.wired_approx    = data[RATE_W-1:0];
            REG_WIRELESS_EXACT:  shadow_cfg.wireless_exact  = data[RATE_W-1:0];
            REG_WIRELESS_APPROX: shadow_cfg.wireless_approx = data[RATE_W-1:0];
            REG_DIST_MAX:        shadow_cfg.dist_max        = data[HOP_W-1:0];
            default:             ;
        endcase
    endtask

    // Load a full register set while the block is idle
    task automatic apply_config(cfg_t c, bit poke_unused);
        logic [CFG_DAT_W-HOP_W-1:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? '1 : (CFG_DAT_W-HOP_W)'($urandom);
        wait_idle();
        put_reg(REG_WIRED_EXACT, c.wired_exact);
        put_reg(REG_WIRED_APPROX, c.wired_approx);
        put_reg(REG_WIRELESS_EXACT, c.wireless_exact);
        put_reg(REG_WIRELESS_APPROX, c.wireless_approx);
        // Upper data bits of the distance register are ignored
        put_reg(REG_DIST_MAX, {junk, c.dist_max});
        if (poke_unused)
            put_reg(REG_UNUSED, CFG_DAT_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        configs_applied++;
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.wired_exact     = RATE_W'($urandom);
        c.wired_approx    = RATE_W'($urandom);
        c.wireless_exact  = RATE_W'($urandom);
        c.wireless_approx = RATE_W'($urandom);
        c.dist_max        = HOP_W'($urandom_range(0, 15));
        return c;
    endfunction

    // Mostly addresses in a small window so that references hit loaded regions
    task automatic send_random(int load_pct);
        logic              op;
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  l;
        int                addr_kind;
        int                len_kind;
        op = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_REF;
        addr_kind = $urandom_range(0, 99);
        len_kind  = $urandom_range(0, 99);
        if (addr_kind < 75)
            a = ADDR_W'($urandom_range(0, WINDOW - 1));
        else if (addr_kind < 85)
            a = ADDR_MAX - ADDR_W'($urandom_range(0, 255));
        else
            a = {16'($urandom), $urandom};
        // Keep loads in the window small, or one region would cover it all
        if (len_kind < 85 || (op == OP_LOAD && addr_kind < 75))
            l = (op == OP_LOAD) ? LEN_W'($urandom_range(0, 255))
                                : LEN_W'($urandom_range(0, 63));
        else if (len_kind < 92)
            l = LEN_MAX;
        else
            l = $urandom;
        send_word(op, a, l, NODE_W'($urandom), NODE_W'($urandom));
    endtask

    task automatic test_mesh_corners();
        send_word(OP_REF, ADDR_MAX, LEN_MAX, 6'd0, 6'd63);
        send_word(OP_REF, '0, '0, 6'd63, 6'd0);
        send_word(OP_REF, 48'd1000, 32'd8, 6'd7, 6'd56);
        send_word(OP_REF, 48'd1000, 32'd8, 6'd56, 6'd7);
        send_word(OP_REF, 48'd1000, 32'd8, 6'd27, 6'd27);
        // Distance equal to the limit stays wired, one more goes wireless
        send_word(OP_REF, 48'd1000, 32'd8, 6'd0, 6'd5);
        send_word(OP_REF, 48'd1000, 32'd8, 6'd0, 6'd6);
        send_word(OP_REF, 48'd1000, 32'd8, 6'd36, 6'd0);
        send_word(OP_REF, 48'd1000, 32'd8, 6'd35, 6'd60);
        wait_idle();
    endtask

    task automatic test_overlap_edges();
        send_word(OP_LOAD, 48'd100, 32'd0, 6'd0, 6'd0);
        send_word(OP_LOAD, 48'd200, 32'd10, 6'd1, 6'd2);
        send_word(OP_LOAD, ADDR_MAX, LEN_MAX, 6'd63, 6'd63);
        // Empty region: hit only by a reference that starts below it and reaches base
        send_word(OP_REF, 48'd99, 32'd0, 6'd9, 6'd18);
        send_word(OP_REF, 48'd99, 32'd1, 6'd9, 6'd18);
        send_word(OP_REF, 48'd100, 32'd0, 6'd9, 6'd18);
        // Reference end is inclusive, region end is base plus size minus one
        send_word(OP_REF, 48'd190, 32'd9, 6'd12, 6'd44);
        send_word(OP_REF, 48'd190, 32'd10, 6'd12, 6'd44);
        send_word(OP_REF, 48'd209, 32'd0, 6'd50, 6'd13);
        send_word(OP_REF, 48'd210, 32'd0, 6'd50, 6'd13);
        send_word(OP_REF, ADDR_MAX, 32'd0, 6'd31, 6'd32);
        send_word(OP_REF, '0, LEN_MAX, 6'd32, 6'd31);
        wait_idle();
    endtask

    task automatic test_route_limits();
        apply_config('{RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX, 4'd0}, 1'b1);
        send_word(OP_REF, 48'd5000, 32'd3, 6'd0, 6'd1);
        send_word(OP_REF, 48'd5000, 32'd3, 6'd9, 6'd9);
        apply_config('{12'd0, 12'd0, 12'd0, 12'd0, 4'd14}, 1'b0);
        send_word(OP_REF, 48'd5000, 32'd3, 6'd0, 6'd63);
        // A limit of 15 can never be exceeded
        apply_config('{RATE_MAX, 12'd1, RATE_MAX, 12'd1, 4'd15}, 1'b0);
        send_word(OP_REF, 48'd5000, 32'd3, 6'd63, 6'd0);
        send_word(OP_REF, 48'd205, 32'd0, 6'd7, 6'd56);
        wait_idle();
    endtask

    task automatic test_nominal_traffic();
        apply_config('{RST_WIRED_EXACT, RST_WIRED_APPROX, RST_WIRELESS_EXACT,
                       RST_WIRELESS_APPROX, RST_DIST_MAX}, 1'b0);
        // Run back to back first, then with random gaps on both sides
        no_idle = 1'b1;
        repeat (100) send_random(12);
        no_idle = 1'b0;
        repeat (350) send_random(12);
        wait_idle();
    endtask

    task automatic test_backpressure();
        no_idle     = 1'b1;
        hold_cycles = LONG_HOLD;
        repeat (40)
            send_word(OP_LOAD, ADDR_W'($urandom_range(0, WINDOW - 1)),
                      LEN_W'($urandom_range(0, 255)), NODE_W'($urandom), NODE_W'($urandom));
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_config_traffic();
        repeat (3)
        begin
            apply_config(random_config(), 1'b0);
            repeat (150) send_random(12);
        end
        wait_idle();
    endtask

    task automatic test_table_fill();
        while (region_fill < DEPTH)
            send_word(OP_LOAD, ADDR_W'($urandom_range(0, WINDOW - 1)),
                      LEN_W'($urandom_range(0, 255)), NODE_W'($urandom), NODE_W'($urandom));
        // Further loads are dropped and flagged
        repeat (6)
            send_word(OP_LOAD, {16'($urandom), $urandom}, $urandom,
                      NODE_W'($urandom), NODE_W'($urandom));
        wait_idle();
    endtask

    task automatic test_full_table_traffic();
        cfg_t c;
        c = random_config();
        c.wired_exact    = RATE_MAX;
        c.wireless_exact = RATE_MAX;
        apply_config(c, 1'b0);
        repeat (450) send_random(15);
        wait_idle();
    endtask

    // Compare one field and report the first few mismatches
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("mismatch on %s: expected %0h, got %0h (result %0d)",
                         name, want, got, results_checked);
        end
    endtask

    task automatic check_result();
        monitor_result_t want;
        if (results_due.size() == 0)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("result word with nothing expected");
            return;
        end
        want = results_due.pop_front();
        results_checked++;
        check_field("table_full", want.table_full, table_full);
        check_field("approx_hit", want.approx_hit, approx_hit);
        check_field("went_wireless", want.went_wireless, went_wireless);
        check_field("wired_hops", want.wired_hops, wired_hops);
        check_field("mesh_hops", want.mesh_hops, mesh_hops);
        check_field("wired_count", want.wired_count, wired_count);
        check_field("wireless_count", want.wireless_count, wireless_count);
        check_field("wired_hops_total", want.wired_hops_total, wired_hops_total);
        check_field("mesh_hops_total", want.mesh_hops_total, mesh_hops_total);
        check_field("energy_exact_total", want.energy_exact_total, energy_exact_total);
        check_field("energy_approx_total", want.energy_approx_total, energy_approx_total);
    endtask

    // Result side: check each accepted word, then draw a stall or serve a long hold
    initial
    begin : result_sink
        int   gap_left;
        logic ready_next;
        gap_left  = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                check_result();
                gap_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                ready_next = 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            out_ready <= ready_next;
        end
    end

    // Watchdog: end the run if it takes far longer than it should
    initial
    begin : watchdog
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, results_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_WIRED_EXACT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        opcode      = OP_LOAD;
        address     = '0;
        length      = '0;
        src_node    = '0;
        dst_node    = '0;
        shadow_cfg  = '{RST_WIRED_EXACT, RST_WIRED_APPROX, RST_WIRELESS_EXACT,
                        RST_WIRELESS_APPROX, RST_DIST_MAX};
        region_fill       = 0;
        wired_tally       = '0;
        wireless_tally    = '0;
        wired_hop_acc     = '0;
        mesh_hop_acc      = '0;
        exact_energy_acc  = '0;
        approx_energy_acc = '0;
        no_idle     = 1'b0;
        hold_cycles = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_mesh_corners();
        test_overlap_edges();
        test_route_limits();
        test_nominal_traffic();
        test_backpressure();
        test_random_config_traffic();
        test_table_fill();
        test_full_table_traffic();

        // Let the block settle, then look for stray or missing words
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
        begin
            failures++;
            $display("%0d expected results never arrived", results_due.size());
        end

        $display("covered %0d words (%0d region loads, %0d dropped on a full table), %0d checked",
                 words_sent, loads_sent, loads_dropped, results_checked);
        $display("references: %0d approximate hits, %0d via wireless hub, %0d register sets",
                 hits_seen, wireless_seen, configs_applied);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
